### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked implication checks with a synchronous reset guard.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold on that edge.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication: when ante holds, cons must hold on the next edge.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/tgr_pkg.sv
// ----------------------------------------------------------------------------
// tgr_pkg
// Shared widths, codes and types of the text console glyph renderer.
// ----------------------------------------------------------------------------
`default_nettype none

package tgr_pkg;

   // Glyph geometry defaults.
   localparam int GLYPH_COLS      = 8;
   localparam int GLYPH_ROWS_DEF  = 16;
   localparam int GLYPH_COUNT_DEF = 95;

   // Field widths.
   localparam int CHAR_W      = 8;
   localparam int FONT_ADDR_W = 11;
   localparam int FONT_BYTE_W = 8;
   localparam int ADDR_W      = 26;
   localparam int PAT_W       = GLYPH_COLS;
   localparam int LINE_W      = 13;
   localparam int COL_W       = 12;
   localparam int PITCH_W     = 15;
   localparam int MODE_W      = 2;
   localparam int XB_W        = 14;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 16;

   // Character codes.
   localparam logic [CHAR_W-1:0] FIRST_PRINTABLE = 8'd32;
   localparam logic [CHAR_W-1:0] LAST_PRINTABLE  = 8'd126;
   localparam logic [CHAR_W-1:0] CODE_NEWLINE    = 8'd10;
   localparam logic [CHAR_W-1:0] CODE_BACKSPACE  = 8'd8;

   // Operations and result kinds.
   localparam logic OP_PUT_CHAR   = 1'b0;
   localparam logic OP_FONT_WRITE = 1'b1;
   localparam logic KIND_ROW      = 1'b0;
   localparam logic KIND_SCROLL   = 1'b1;

   // Pixel modes.
   localparam logic [MODE_W-1:0] MODE_8BPP  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_24BPP = 2'd1;
   localparam logic [MODE_W-1:0] MODE_32BPP = 2'd2;

   // Register indexes.
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;
   localparam csr_idx_type REG_SCREEN_WIDTH  = 2'd0;
   localparam csr_idx_type REG_SCREEN_HEIGHT = 2'd1;
   localparam csr_idx_type REG_LINE_PITCH    = 2'd2;
   localparam csr_idx_type REG_PIXEL_MODE    = 2'd3;

   // Register reset values.
   localparam logic [LINE_W-1:0]  RST_SCREEN_WIDTH  = 13'd640;
   localparam logic [LINE_W-1:0]  RST_SCREEN_HEIGHT = 13'd480;
   localparam logic [PITCH_W-1:0] RST_LINE_PITCH    = 15'd2560;
   localparam logic [MODE_W-1:0]  RST_PIXEL_MODE    = MODE_32BPP;

   // Address accumulator commands.
   typedef logic [1:0] acc_cmd_type;
   localparam acc_cmd_type ACC_HOLD = 2'd0;
   localparam acc_cmd_type ACC_LOAD = 2'd1;
   localparam acc_cmd_type ACC_STEP = 2'd2;

endpackage

`default_nettype wire

### sv/tgr_if.sv
// ----------------------------------------------------------------------------
// tgr_if
// Valid/ready channels of the renderer: requests, responses and registers.
// ----------------------------------------------------------------------------
`default_nettype none

interface tgr_req_if;
   import tgr_pkg::*;
   logic                   valid;
   logic                   ready;
   logic                   op;
   logic [CHAR_W-1:0]      char_code;
   logic [FONT_ADDR_W-1:0] font_address;
   logic [FONT_BYTE_W-1:0] font_byte;
   modport source (output valid, op, char_code, font_address, font_byte, input ready);
   modport sink   (input valid, op, char_code, font_address, font_byte, output ready);
endinterface

interface tgr_rsp_if;
   import tgr_pkg::*;
   logic              valid;
   logic              ready;
   logic              kind;
   logic [ADDR_W-1:0] byte_address;
   logic [PAT_W-1:0]  pattern;
   logic [PAT_W-1:0]  column_enable;
   logic [LINE_W-1:0] scroll_lines;
   logic              last;
   modport source (output valid, kind, byte_address, pattern, column_enable,
                   scroll_lines, last, input ready);
   modport sink   (input valid, kind, byte_address, pattern, column_enable,
                   scroll_lines, last, output ready);
endinterface

interface tgr_csr_if;
   import tgr_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### sv/tgr_font_mem.sv
// ----------------------------------------------------------------------------
// tgr_font_mem
// Glyph row store: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module tgr_font_mem #(
   parameter int DEPTH = 1520,
   parameter int AW    = 11
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [7:0]    wr_data,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output logic      [7:0]    rd_data
);

   logic [7:0] mem_ff [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read data holds while rd_en is low so a stalled consumer sees it stay.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### sv/tgr_addr_acc.sv
// ----------------------------------------------------------------------------
// tgr_addr_acc
// Framebuffer address accumulator built around one shared adder.
// ----------------------------------------------------------------------------
`default_nettype none

module tgr_addr_acc (
   input  wire logic                         clock,
   input  wire tgr_pkg::acc_cmd_type         cmd,
   input  wire logic [tgr_pkg::ADDR_W-1:0]   load_base,
   input  wire logic [tgr_pkg::XB_W-1:0]     load_offset,
   input  wire logic [tgr_pkg::PITCH_W-1:0]  step,
   output logic      [tgr_pkg::ADDR_W-1:0]   addr
);
   import tgr_pkg::*;

   logic [ADDR_W-1:0] addr_ff;
   logic [ADDR_W-1:0] addr_in;
   logic [ADDR_W-1:0] opa;
   logic [ADDR_W-1:0] opb;

   // Loading adds the line base and the column offset; stepping adds one
   // line pitch. Both go through the same adder, modulo the address width.
   always_comb begin
      opa     = addr_ff;
      opb     = ADDR_W'(step);
      addr_in = addr_ff;
      unique case (cmd)
         ACC_LOAD: begin
            opa     = load_base;
            opb     = ADDR_W'(load_offset);
            addr_in = opa + opb;
         end
         ACC_STEP: begin
            addr_in = opa + opb;
         end
         default: begin
            addr_in = addr_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
   end

   assign addr = addr_ff;

endmodule

`default_nettype wire

### sv/text_console_glyph_renderer.sv
// ----------------------------------------------------------------------------
// text_console_glyph_renderer
// Character-at-a-time text console that turns glyphs into framebuffer rows.
// ----------------------------------------------------------------------------
// Usage: an item on req_ch either loads one font byte (op = 1) or prints one
// character at the cursor (op = 0). Each printed glyph yields one rsp_ch item
// per visible glyph row (byte address, pattern, column enable), then possibly
// one scroll item; the final item of a character carries last. Registers are
// written through csr_ch, which is always ready; the user must write them
// only while the block is idle, which the block itself does not enforce.
// A font write leaves the sequencer idle. A character passes through the
// CALC, WRAP, BASE and DIV states, then ROW, which emits its glyph rows, and
// finally SCROLL; the row sequencer reads the font memory and steps the
// address accumulator once per row.
// req_ch.ready is high only while the sequencer is idle.
// Reset clears the cursor to the top left, restores the register defaults
// and drops any pending response. The font memory is not cleared.
// A stalled receiver freezes the row sequencer; the font read data and the
// address accumulator hold until the output register frees up.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module text_console_glyph_renderer #(
   parameter int GLYPH_ROWS  = tgr_pkg::GLYPH_ROWS_DEF,
   parameter int GLYPH_COUNT = tgr_pkg::GLYPH_COUNT_DEF
) (
   input  wire logic  clock,
   input  wire logic  reset,
   tgr_req_if.sink    req_ch,
   tgr_rsp_if.source  rsp_ch,
   tgr_csr_if.sink    csr_ch
);
   import tgr_pkg::*;

   // Font store geometry.
   localparam int FONT_DEPTH = GLYPH_COUNT * GLYPH_ROWS;
   localparam int FONT_AW    = $clog2(FONT_DEPTH);
   // Row counter must reach GLYPH_ROWS itself.
   localparam int RC_W       = $clog2(GLYPH_ROWS + 1);
   // Scroll count: ceil division by GLYPH_ROWS done as a reciprocal multiply,
   // exact for every LINE_W-bit dividend.
   localparam int DIV_SHIFT  = LINE_W + $clog2(GLYPH_ROWS);
   localparam int DIV_RECIP  = ((1 << DIV_SHIFT) + GLYPH_ROWS - 1) / GLYPH_ROWS;
   localparam int RECIP_W    = $clog2(DIV_RECIP + 1);
   localparam int QPROD_W    = LINE_W + RECIP_W;
   localparam int MUL_W      = COL_W + PITCH_W;

   // Sequencer states.
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_CALC   = 3'd1;
   localparam logic [2:0] ST_WRAP   = 3'd2;
   localparam logic [2:0] ST_BASE   = 3'd3;
   localparam logic [2:0] ST_DIV    = 3'd4;
   localparam logic [2:0] ST_ROW    = 3'd5;
   localparam logic [2:0] ST_SCROLL = 3'd6;

   // Control state.
   logic [2:0]        state_ff, state_in;
   logic [COL_W-1:0]  cursor_col_ff, cursor_col_in;
   logic [COL_W-1:0]  cursor_row_ff, cursor_row_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // Configuration registers.
   logic [LINE_W-1:0]  width_ff;
   logic [LINE_W-1:0]  height_ff;
   logic [PITCH_W-1:0] pitch_ff;
   logic [MODE_W-1:0]  mode_ff;

   // Per-character working registers.
   logic [CHAR_W-1:0]  code_ff;
   logic               draw_ff, draw_in;
   logic [COL_W-1:0]   draw_x_ff, draw_x_in;
   logic [LINE_W-1:0]  x_after_ff, x_after_in;
   logic [LINE_W-1:0]  y_after_ff, y_after_in;
   logic [ADDR_W-1:0]  prod_ff, prod_in;
   logic [FONT_AW-1:0] glyph_base_ff, glyph_base_in;
   logic [COL_W-1:0]   x_fin_ff, x_fin_in;
   logic [LINE_W-1:0]  y2_ff, y2_in;
   logic [XB_W-1:0]    xb_ff, xb_in;
   logic [PAT_W-1:0]   en_ff, en_in;
   logic [LINE_W-1:0]  lim_ff, lim_in;
   logic               over_ff, over_in;
   logic [LINE_W-1:0]  dist_ff, dist_in;
   logic [LINE_W-1:0]  n_ff, n_in;
   logic [LINE_W-1:0]  line_ff;
   logic [RC_W-1:0]    row_cnt_ff;
   logic [FONT_AW-1:0] font_idx_ff;

   // Output register payload.
   logic              rsp_kind_ff, rsp_kind_in;
   logic [ADDR_W-1:0] rsp_addr_ff, rsp_addr_in;
   logic [PAT_W-1:0]  rsp_pattern_ff, rsp_pattern_in;
   logic [PAT_W-1:0]  rsp_enable_ff, rsp_enable_in;
   logic [LINE_W-1:0] rsp_lines_ff, rsp_lines_in;
   logic              rsp_last_ff, rsp_last_in;

   // Sequencer strobes.
   logic              req_accept;
   logic              csr_accept;
   logic              out_free;
   logic              row_ok;
   logic              next_ok;
   logic              rsp_load;
   logic              rsp_is_scroll;
   logic              row_advance;
   logic              cursor_upd;
   logic              rd_en;
   acc_cmd_type       acc_cmd;

   // Datapath helpers.
   logic              is_nl;
   logic              is_bs;
   logic              is_print;
   logic [COL_W-1:0]  bs_x;
   logic              wrap;
   logic [QPROD_W-1:0] quot_prod;
   logic [LINE_W-1:0] amount;
   logic [LINE_W-1:0] y_fin;
   logic [ADDR_W-1:0] acc_addr;
   logic [7:0]        font_rd_data;
   logic              font_wr_en;

   assign req_accept = req_ch.valid && req_ch.ready;
   assign csr_accept = csr_ch.valid && csr_ch.ready;
   assign out_free   = !rsp_valid_ff || rsp_ch.ready;

   // Font bytes beyond the store are dropped.
   assign font_wr_en = req_accept && (req_ch.op == OP_FONT_WRITE) &&
                       (int'(req_ch.font_address) < FONT_DEPTH);

   // ------------------------------------------------------------------------
   // Decode (ST_CALC): character class, drawing column, cursor advance, the
   // line base product and the glyph's first font index.
   // ------------------------------------------------------------------------
   assign is_nl    = (code_ff == CODE_NEWLINE);
   assign is_bs    = (code_ff == CODE_BACKSPACE);
   assign is_print = (code_ff >= FIRST_PRINTABLE) && (code_ff <= LAST_PRINTABLE);
   assign bs_x     = (cursor_col_ff >= COL_W'(GLYPH_COLS)) ?
                     cursor_col_ff - COL_W'(GLYPH_COLS) : '0;

   assign draw_in   = is_bs || is_print;
   assign draw_x_in = is_bs ? bs_x : cursor_col_ff;

   always_comb begin
      if (is_nl) begin
         x_after_in = '0;
      end else if (is_bs) begin
         x_after_in = LINE_W'(bs_x);
      end else begin
         x_after_in = LINE_W'(cursor_col_ff) + LINE_W'(GLYPH_COLS);
      end
   end

   assign y_after_in = is_nl ? LINE_W'(cursor_row_ff) + LINE_W'(GLYPH_ROWS)
                             : LINE_W'(cursor_row_ff);

   assign prod_in = ADDR_W'(MUL_W'(cursor_row_ff) * MUL_W'(pitch_ff));

   // A backspace draws a space, which is glyph zero.
   assign glyph_base_in = is_bs ? '0 :
                          FONT_AW'(32'(code_ff - FIRST_PRINTABLE) * GLYPH_ROWS);

   // ------------------------------------------------------------------------
   // Wrap (ST_WRAP): width wrap, column byte offset, clipping mask and the
   // lowest cursor row that still fits a whole glyph.
   // ------------------------------------------------------------------------
   assign wrap     = (x_after_ff >= width_ff);
   assign x_fin_in = wrap ? '0 : x_after_ff[COL_W-1:0];
   assign y2_in    = wrap ? y_after_ff + LINE_W'(GLYPH_ROWS) : y_after_ff;
   assign lim_in   = (height_ff >= LINE_W'(GLYPH_ROWS)) ?
                     height_ff - LINE_W'(GLYPH_ROWS) : '0;

   always_comb begin
      case (mode_ff)
         MODE_8BPP:  xb_in = XB_W'(draw_x_ff);
         MODE_32BPP: xb_in = XB_W'({draw_x_ff, 2'b00});
         default:    xb_in = XB_W'({draw_x_ff, 1'b0}) + XB_W'(draw_x_ff);
      endcase
   end

   always_comb begin
      for (int j = 0; j < GLYPH_COLS; j++) begin
         en_in[GLYPH_COLS-1-j] = (LINE_W'(draw_x_ff) + LINE_W'(j)) < width_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Base (ST_BASE): scroll decision and the rounded-up distance to move.
   // Div (ST_DIV): number of text lines to scroll.
   // ------------------------------------------------------------------------
   assign over_in   = (y2_ff > lim_ff);
   assign dist_in   = y2_ff - lim_ff + LINE_W'(GLYPH_ROWS - 1);
   assign quot_prod = QPROD_W'(dist_ff) * QPROD_W'(DIV_RECIP);
   assign n_in      = LINE_W'(quot_prod >> DIV_SHIFT);
   assign amount    = LINE_W'(n_ff * LINE_W'(GLYPH_ROWS));
   assign y_fin     = over_ff ? y2_ff - amount : y2_ff;

   // ------------------------------------------------------------------------
   // Row loop: a row is drawn while it is inside the glyph and above the
   // bottom edge; the first row below the screen ends the glyph.
   // ------------------------------------------------------------------------
   assign row_ok  = draw_ff && (row_cnt_ff != RC_W'(GLYPH_ROWS)) &&
                    (line_ff < height_ff);
   assign next_ok = (row_cnt_ff != RC_W'(GLYPH_ROWS - 1)) &&
                    ((line_ff + LINE_W'(1)) < height_ff);

   always_comb begin
      state_in      = state_ff;
      rsp_load      = 1'b0;
      rsp_is_scroll = 1'b0;
      row_advance   = 1'b0;
      cursor_upd    = 1'b0;
      rd_en         = 1'b0;
      acc_cmd       = ACC_HOLD;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && (req_ch.op == OP_PUT_CHAR)) begin
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            state_in = ST_WRAP;
         end
         ST_WRAP: begin
            state_in = ST_BASE;
         end
         ST_BASE: begin
            acc_cmd  = ACC_LOAD;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            // Fetch the first glyph row ahead of the row loop.
            rd_en    = draw_ff;
            state_in = ST_ROW;
         end
         ST_ROW: begin
            if (!row_ok) begin
               state_in = ST_SCROLL;
            end else if (out_free) begin
               rsp_load    = 1'b1;
               acc_cmd     = ACC_STEP;
               row_advance = 1'b1;
               rd_en       = next_ok;
            end
         end
         ST_SCROLL: begin
            if (!over_ff) begin
               cursor_upd = 1'b1;
               state_in   = ST_IDLE;
            end else if (out_free) begin
               rsp_load      = 1'b1;
               rsp_is_scroll = 1'b1;
               cursor_upd    = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Response payload: a glyph row or a scroll command, unused fields zero.
   assign rsp_kind_in    = rsp_is_scroll ? KIND_SCROLL : KIND_ROW;
   assign rsp_addr_in    = rsp_is_scroll ? '0 : acc_addr;
   assign rsp_pattern_in = rsp_is_scroll ? '0 : font_rd_data;
   assign rsp_enable_in  = rsp_is_scroll ? '0 : en_ff;
   assign rsp_lines_in   = rsp_is_scroll ? amount : '0;
   assign rsp_last_in    = rsp_is_scroll || (!next_ok && !over_ff);

   assign rsp_valid_in  = rsp_load ? 1'b1 : (rsp_ch.ready ? 1'b0 : rsp_valid_ff);
   assign cursor_col_in = cursor_upd ? x_fin_ff : cursor_col_ff;
   assign cursor_row_in = cursor_upd ? y_fin[COL_W-1:0] : cursor_row_ff;

   // ------------------------------------------------------------------------
   // Registers.
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cursor_col_ff <= '0;
         cursor_row_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cursor_col_ff <= cursor_col_in;
         cursor_row_ff <= cursor_row_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= RST_SCREEN_WIDTH;
         height_ff <= RST_SCREEN_HEIGHT;
         pitch_ff  <= RST_LINE_PITCH;
         mode_ff   <= RST_PIXEL_MODE;
      end else if (csr_accept) begin
         unique case (csr_ch.index)
            REG_SCREEN_WIDTH:  width_ff  <= csr_ch.data[LINE_W-1:0];
            REG_SCREEN_HEIGHT: height_ff <= csr_ch.data[LINE_W-1:0];
            REG_LINE_PITCH:    pitch_ff  <= csr_ch.data[PITCH_W-1:0];
            REG_PIXEL_MODE:    mode_ff   <= csr_ch.data[MODE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         code_ff <= req_ch.char_code;
      end
      if (state_ff == ST_CALC) begin
         draw_ff       <= draw_in;
         draw_x_ff     <= draw_x_in;
         x_after_ff    <= x_after_in;
         y_after_ff    <= y_after_in;
         prod_ff       <= prod_in;
         glyph_base_ff <= glyph_base_in;
      end
      if (state_ff == ST_WRAP) begin
         x_fin_ff <= x_fin_in;
         y2_ff    <= y2_in;
         xb_ff    <= xb_in;
         en_ff    <= en_in;
         lim_ff   <= lim_in;
      end
      if (state_ff == ST_BASE) begin
         over_ff     <= over_in;
         dist_ff     <= dist_in;
         line_ff     <= LINE_W'(cursor_row_ff);
         row_cnt_ff  <= '0;
         font_idx_ff <= glyph_base_ff;
      end
      if (state_ff == ST_DIV) begin
         n_ff        <= n_in;
         font_idx_ff <= font_idx_ff + FONT_AW'(1);
      end
      if (row_advance) begin
         line_ff     <= line_ff + LINE_W'(1);
         row_cnt_ff  <= row_cnt_ff + RC_W'(1);
         font_idx_ff <= font_idx_ff + FONT_AW'(1);
      end
      if (rsp_load) begin
         rsp_kind_ff    <= rsp_kind_in;
         rsp_addr_ff    <= rsp_addr_in;
         rsp_pattern_ff <= rsp_pattern_in;
         rsp_enable_ff  <= rsp_enable_in;
         rsp_lines_ff   <= rsp_lines_in;
         rsp_last_ff    <= rsp_last_in;
      end
   end

   // ------------------------------------------------------------------------
   // Submodules.
   // ------------------------------------------------------------------------
   tgr_font_mem #(
      .DEPTH (FONT_DEPTH),
      .AW    (FONT_AW)
   ) u_font_mem (
      .clock   (clock),
      .wr_en   (font_wr_en),
      .wr_addr (FONT_AW'(req_ch.font_address)),
      .wr_data (req_ch.font_byte),
      .rd_en   (rd_en),
      .rd_addr (font_idx_ff),
      .rd_data (font_rd_data)
   );

   tgr_addr_acc u_addr_acc (
      .clock       (clock),
      .cmd         (acc_cmd),
      .load_base   (prod_ff),
      .load_offset (xb_ff),
      .step        (pitch_ff),
      .addr        (acc_addr)
   );

   // ------------------------------------------------------------------------
   // Ports.
   // ------------------------------------------------------------------------
   assign req_ch.ready         = (state_ff == ST_IDLE);
   assign csr_ch.ready         = 1'b1;
   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.kind          = rsp_kind_ff;
   assign rsp_ch.byte_address  = rsp_addr_ff;
   assign rsp_ch.pattern       = rsp_pattern_ff;
   assign rsp_ch.column_enable = rsp_enable_ff;
   assign rsp_ch.scroll_lines  = rsp_lines_ff;
   assign rsp_ch.last          = rsp_last_ff;

   // ------------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------------
   `ASSERT_IMPLIES(a_scroll_is_last, clock, reset, rsp_valid_ff && (rsp_kind_ff == KIND_SCROLL), rsp_last_ff, "scroll item without last flag")
   `ASSERT_IMPLIES(a_font_write_idle, clock, reset, font_wr_en, state_ff == ST_IDLE, "font write while busy")
   `ASSERT_IMPLIES(a_row_bound, clock, reset, state_ff == ST_ROW, row_cnt_ff <= RC_W'(GLYPH_ROWS), "row counter past glyph height")
   `ASSERT_NEXT(a_cursor_hold, clock, reset, state_ff != ST_SCROLL, $stable(cursor_col_ff) && $stable(cursor_row_ff), "cursor moved outside scroll step")

endmodule

`default_nettype wire

### tb/text_console_glyph_renderer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_glyph_renderer_test
// Self-checking bench for the text console glyph renderer. Character and
// font items go in on the request channel. An in-bench model of the cursor,
// font store and registers predicts every row and scroll command. The
// commands on the response channel are compared field by field, in order.
// ----------------------------------------------------------------------------
module text_console_glyph_renderer_test;
   import tgr_pkg::*;

   localparam int ROWS             = GLYPH_ROWS_DEF;
   localparam int STORE_DEPTH      = GLYPH_COUNT_DEF * GLYPH_ROWS_DEF;
   // The fourth pixel mode has no name in the package; it renders as 24bpp.
   localparam logic [MODE_W-1:0] MODE_UNDEFINED = 2'd3;
   // Glyphs that the bench loads besides the space and the tilde. The solid
   // and the empty glyph give both pattern extremes.
   localparam logic [CHAR_W-1:0] CODE_SOLID  = 8'd33;
   localparam logic [CHAR_W-1:0] CODE_EMPTY  = 8'd34;
   localparam logic [CHAR_W-1:0] CODE_LETTER = 8'd65;
   // Settling time that covers any character still in flight after its last
   // expected command has been seen.
   localparam int SETTLE_CYCLES    = 40;
   // Longest run of cycles without any handshake before the run is abandoned.
   localparam int QUIET_LIMIT      = 2000;
   localparam int RANDOM_PER_PHASE = 20;
   localparam int TAIL_CHARS       = 6;
   localparam int NEWLINE_WALK     = 24;
   localparam int SILENT_RUN       = 30;
   localparam int MAX_PRINTED      = 60;

   // One request item as the driver sends it.
   typedef struct packed {
      logic                   op;
      logic [CHAR_W-1:0]      char_code;
      logic [FONT_ADDR_W-1:0] font_address;
      logic [FONT_BYTE_W-1:0] font_byte;
   } console_req_type;

   // One framebuffer command as the block should produce it.
   typedef struct packed {
      logic              kind;
      logic [ADDR_W-1:0] byte_address;
      logic [PAT_W-1:0]  pattern;
      logic [PAT_W-1:0]  column_enable;
      logic [LINE_W-1:0] scroll_lines;
      logic              last;
   } fb_cmd_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   tgr_req_if req_ch ();
   tgr_rsp_if rsp_ch ();
   tgr_csr_if csr_ch ();

   text_console_glyph_renderer dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // Items waiting for the driver, and the commands the console still owes.
   console_req_type pending_items[$];
   fb_cmd_type      expected_commands[$];

   // The bench's own copy of the console state and its registers.
   logic [LINE_W-1:0]      width_reg;
   logic [LINE_W-1:0]      height_reg;
   logic [PITCH_W-1:0]     pitch_reg;
   logic [MODE_W-1:0]      mode_reg;
   logic [COL_W-1:0]       cursor_x;
   logic [COL_W-1:0]       cursor_y;
   logic [FONT_BYTE_W-1:0] font_rom [STORE_DEPTH];

   console_req_type held_item;
   fb_cmd_type      want;
   int              error_count = 0;
   int              results_seen = 0;
   int              quiet_cycles = 0;
   // While set, neither side inserts idle or stall cycles.
   logic            steady = 1'b0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Every input of the block starts at a known value.
   initial begin
      req_ch.valid        = 1'b0;
      req_ch.op           = OP_PUT_CHAR;
      req_ch.char_code    = '0;
      req_ch.font_address = '0;
      req_ch.font_byte    = '0;
      rsp_ch.ready        = 1'b0;
      csr_ch.valid        = 1'b0;
      csr_ch.index        = REG_SCREEN_WIDTH;
      csr_ch.data         = '0;
   end

   task automatic report_mismatch(input string line);
      error_count++;
      if (error_count <= MAX_PRINTED) $display("error: %s", line);
   endtask

   // Emits the visible rows of one glyph at pixel position (x, y) into the
   // expected stream and returns how many rows were emitted. Rows at or below
   // the screen height end the glyph; rows past the width are still emitted,
   // only their column enable is clipped.
   function automatic int draw_rows(input int unsigned x, input int unsigned y,
                                    input logic [CHAR_W-1:0] code);
      fb_cmd_type      cmd;
      int unsigned     bpp;
      int unsigned     base;
      logic [PAT_W-1:0] en;
      longint unsigned addr;
      int              count;
      count = 0;
      if (code < FIRST_PRINTABLE || code > LAST_PRINTABLE) return 0;
      case (mode_reg)
         MODE_8BPP:  bpp = 1;
         MODE_32BPP: bpp = 4;
         default:    bpp = 3;
      endcase
      base = (int'(code) - int'(FIRST_PRINTABLE)) * ROWS;
      en = '0;
      for (int j = 0; j < GLYPH_COLS; j++) begin
         if (x + j < width_reg) en[GLYPH_COLS-1-j] = 1'b1;
      end
      for (int i = 0; i < ROWS; i++) begin
         if (y + i >= height_reg) break;
         addr = longint'(y + i) * pitch_reg + longint'(x) * bpp;
         cmd               = '0;
         cmd.kind          = KIND_ROW;
         cmd.byte_address  = addr[ADDR_W-1:0];
         cmd.pattern       = font_rom[base+i];
         cmd.column_enable = en;
         expected_commands.push_back(cmd);
         count++;
      end
      return count;
   endfunction

   // Applies one accepted item to the console model and queues the commands
   // it causes, with last set on the final one.
   task automatic predict_commands(input console_req_type it);
      fb_cmd_type  cmd;
      int unsigned x;
      int unsigned y;
      int unsigned lim;
      int unsigned n;
      int          count;
      if (it.op == OP_FONT_WRITE) begin
         // Addresses beyond the store are silently dropped.
         if (it.font_address < STORE_DEPTH) font_rom[it.font_address] = it.font_byte;
         return;
      end
      x = cursor_x;
      y = cursor_y;
      count = 0;
      if (it.char_code == CODE_NEWLINE) begin
         x = 0;
         y += ROWS;
      end else if (it.char_code == CODE_BACKSPACE) begin
         // Step back one cell, clamped at the left edge, and blank it.
         x = (x >= GLYPH_COLS) ? x - GLYPH_COLS : 0;
         count = draw_rows(x, y, FIRST_PRINTABLE);
      end else begin
         // Non-printable codes draw nothing yet still move the cursor.
         count = draw_rows(x, y, it.char_code);
         x += GLYPH_COLS;
      end
      if (x >= width_reg) begin
         x = 0;
         y += ROWS;
      end
      // On a screen shorter than one glyph the lowest text line is line zero.
      lim = (height_reg >= ROWS) ? height_reg - ROWS : 0;
      if (y > lim) begin
         n = (y - lim + ROWS - 1) / ROWS;
         y -= n * ROWS;
         cmd              = '0;
         cmd.kind         = KIND_SCROLL;
         cmd.scroll_lines = LINE_W'(n * ROWS);
         expected_commands.push_back(cmd);
         count++;
      end
      // The cursor registers are 12 bits wide and wrap.
      cursor_x = COL_W'(x);
      cursor_y = COL_W'(y);
      if (count > 0) expected_commands[expected_commands.size()-1].last = 1'b1;
   endtask

   // Request driver: a new item is presented whenever the previous one has
   // been taken, except on random idle cycles.
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            predict_commands(held_item);
            quiet_cycles = 0;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (pending_items.size() != 0 && (steady || $urandom_range(99) >= 10)) begin
               held_item = pending_items.pop_front();
               req_ch.op           <= held_item.op;
               req_ch.char_code    <= held_item.char_code;
               req_ch.font_address <= held_item.font_address;
               req_ch.font_byte    <= held_item.font_byte;
               req_ch.valid        <= 1'b1;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: random back-pressure, and every accepted command is
   // checked against the oldest prediction.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            quiet_cycles = 0;
            if (expected_commands.size() == 0) begin
               report_mismatch($sformatf("command %0d arrived with none expected (kind %0d)",
                                         results_seen, rsp_ch.kind));
            end else begin
               want = expected_commands.pop_front();
               if (rsp_ch.kind !== want.kind)
                  report_mismatch($sformatf("command %0d kind %0h, expected %0h",
                                            results_seen, rsp_ch.kind, want.kind));
               if (rsp_ch.byte_address !== want.byte_address)
                  report_mismatch($sformatf("command %0d byte_address %0h, expected %0h",
                                            results_seen, rsp_ch.byte_address,
                                            want.byte_address));
               if (rsp_ch.pattern !== want.pattern)
                  report_mismatch($sformatf("command %0d pattern %0h, expected %0h",
                                            results_seen, rsp_ch.pattern, want.pattern));
               if (rsp_ch.column_enable !== want.column_enable)
                  report_mismatch($sformatf("command %0d column_enable %0h, expected %0h",
                                            results_seen, rsp_ch.column_enable,
                                            want.column_enable));
               if (rsp_ch.scroll_lines !== want.scroll_lines)
                  report_mismatch($sformatf("command %0d scroll_lines %0d, expected %0d",
                                            results_seen, rsp_ch.scroll_lines,
                                            want.scroll_lines));
               if (rsp_ch.last !== want.last)
                  report_mismatch($sformatf("command %0d last %0b, expected %0b",
                                            results_seen, rsp_ch.last, want.last));
            end
            results_seen++;
         end
         rsp_ch.ready <= steady || ($urandom_range(99) >= 10);
      end
   end

   // Watchdog: a hung handshake ends the run.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_ch.valid && csr_ch.ready) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   function automatic console_req_type char_item(input logic [CHAR_W-1:0] code);
      console_req_type it;
      it.op           = OP_PUT_CHAR;
      it.char_code    = code;
      // The font fields are don't-care for a character, so keep them moving.
      it.font_address = FONT_ADDR_W'($urandom_range(0, 2047));
      it.font_byte    = FONT_BYTE_W'($urandom_range(0, 255));
      return it;
   endfunction

   function automatic console_req_type font_item(input int unsigned addr,
                                                 input int unsigned value);
      console_req_type it;
      it.op           = OP_FONT_WRITE;
      it.char_code    = CHAR_W'($urandom_range(0, 255));
      it.font_address = FONT_ADDR_W'(addr);
      it.font_byte    = FONT_BYTE_W'(value);
      return it;
   endfunction

   // A code that moves the cursor without drawing anything.
   function automatic logic [CHAR_W-1:0] silent_code();
      logic [CHAR_W-1:0] c;
      c = $urandom_range(1) ? CHAR_W'($urandom_range(127, 255))
                            : CHAR_W'($urandom_range(0, 31));
      if (c == CODE_BACKSPACE || c == CODE_NEWLINE) c = 8'd0;
      return c;
   endfunction

   // A printable code whose glyph has been loaded.
   function automatic logic [CHAR_W-1:0] loaded_code();
      logic [CHAR_W-1:0] c;
      case ($urandom_range(0, 4))
         0:       c = FIRST_PRINTABLE;
         1:       c = CODE_SOLID;
         2:       c = CODE_EMPTY;
         3:       c = CODE_LETTER;
         default: c = LAST_PRINTABLE;
      endcase
      return c;
   endfunction

   // Queues the font writes for all rows of one glyph.
   task automatic load_glyph(input logic [CHAR_W-1:0] code);
      int unsigned base;
      int unsigned fill;
      base = (int'(code) - int'(FIRST_PRINTABLE)) * ROWS;
      for (int r = 0; r < ROWS; r++) begin
         if (code == CODE_SOLID) fill = 8'hFF;
         else if (code == CODE_EMPTY) fill = 8'h00;
         else fill = $urandom_range(0, 255);
         pending_items.push_back(font_item(base + r, fill));
      end
   endtask

   // Mostly printable text, with line control, stray codes and font updates.
   // Font writes land anywhere, in range or beyond the store; only loaded
   // glyphs are ever printed, so no unwritten row is read.
   function automatic console_req_type random_item();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 8) return font_item($urandom_range(0, 2047), $urandom_range(0, 255));
      if (r < 16) return char_item(CODE_NEWLINE);
      if (r < 24) return char_item(CODE_BACKSPACE);
      if (r < 30) return char_item(silent_code());
      return char_item(loaded_code());
   endfunction

   task automatic queue_random(input int count);
      repeat (count) pending_items.push_back(random_item());
   endtask

   // Printable text at the end of a phase usually leaves the cursor away from
   // the left edge, so the next setting starts from an arbitrary position.
   task automatic queue_text(input int count);
      repeat (count) pending_items.push_back(char_item(loaded_code()));
   endtask

   // Waits until every item has been taken and every command seen, then
   // gives a character that emits nothing time to finish.
   task automatic wait_idle();
      do @(negedge clock);
      while (pending_items.size() != 0 || req_ch.valid || expected_commands.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input csr_idx_type idx, input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      csr_ch.valid <= 1'b1;
      do @(posedge clock);
      while (!csr_ch.ready);
      case (idx)
         REG_SCREEN_WIDTH:  width_reg  = value[LINE_W-1:0];
         REG_SCREEN_HEIGHT: height_reg = value[LINE_W-1:0];
         REG_LINE_PITCH:    pitch_reg  = value[PITCH_W-1:0];
         REG_PIXEL_MODE:    mode_reg   = value[MODE_W-1:0];
         default: ;
      endcase
      csr_ch.valid <= 1'b0;
   endtask

   task automatic set_screen(input int unsigned w, input int unsigned h,
                             input int unsigned p, input int unsigned m);
      write_reg(REG_SCREEN_WIDTH, CSR_DATA_W'(w));
      write_reg(REG_SCREEN_HEIGHT, CSR_DATA_W'(h));
      write_reg(REG_LINE_PITCH, CSR_DATA_W'(p));
      write_reg(REG_PIXEL_MODE, CSR_DATA_W'(m));
   endtask

   // Random screen geometry, biased toward narrow and short screens where
   // wrapping, clipping and scrolling happen often.
   task automatic random_screen();
      set_screen($urandom_range(1) ? $urandom_range(8, 160) : $urandom_range(8, 4096),
                 $urandom_range(1) ? $urandom_range(16, 96) : $urandom_range(16, 4096),
                 $urandom_range(1, 16384), $urandom_range(0, 3));
   endtask

   initial begin
      width_reg  = RST_SCREEN_WIDTH;
      height_reg = RST_SCREEN_HEIGHT;
      pitch_reg  = RST_LINE_PITCH;
      mode_reg   = RST_PIXEL_MODE;
      cursor_x   = '0;
      cursor_y   = '0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Load every glyph that is printed before any character goes in, so
      // that no glyph row is ever read before it has been written.
      load_glyph(FIRST_PRINTABLE);
      load_glyph(CODE_SOLID);
      load_glyph(CODE_EMPTY);
      load_glyph(CODE_LETTER);
      load_glyph(LAST_PRINTABLE);
      wait_idle();

      // Directed checks at the reset geometry of 640 by 480, 32bpp.
      pending_items.push_back(font_item(STORE_DEPTH - 1, 8'hA5));  // last row of '~'
      pending_items.push_back(font_item(STORE_DEPTH, 8'h3C));      // first address past the store
      pending_items.push_back(font_item(2047, 8'hFF));             // all address bits set
      pending_items.push_back(char_item(LAST_PRINTABLE));
      pending_items.push_back(char_item(FIRST_PRINTABLE));
      pending_items.push_back(char_item(CODE_SOLID));
      pending_items.push_back(char_item(CODE_EMPTY));
      pending_items.push_back(char_item(FIRST_PRINTABLE - 8'd1));  // just below printable
      pending_items.push_back(char_item(LAST_PRINTABLE + 8'd1));   // just above printable
      pending_items.push_back(char_item(8'd0));
      pending_items.push_back(char_item(8'd255));
      pending_items.push_back(char_item(CODE_BACKSPACE));
      pending_items.push_back(char_item(CODE_NEWLINE));
      pending_items.push_back(char_item(CODE_BACKSPACE));          // clamps at column zero
      pending_items.push_back(font_item(0, 8'h81));
      pending_items.push_back(char_item(FIRST_PRINTABLE));
      pending_items.push_back(char_item(CODE_LETTER));
      pending_items.push_back(char_item(CODE_NEWLINE));
      pending_items.push_back(char_item(CODE_NEWLINE));
      queue_random(RANDOM_PER_PHASE);
      queue_text(TAIL_CHARS);
      wait_idle();

      // Smallest screen, one cell: all but backspaces scroll, and text wraps.
      set_screen(8, 16, 1, MODE_8BPP);
      queue_random(RANDOM_PER_PHASE);
      queue_text(TAIL_CHARS);
      wait_idle();

      // Largest screen and pitch, run without any idling. Newlines walk the
      // cursor down a few dozen text lines, with a glyph now and then.
      steady = 1'b1;
      set_screen(4096, 4096, 16384, MODE_24BPP);
      for (int i = 0; i < NEWLINE_WALK; i++) begin
         if (i % 8 == 7) pending_items.push_back(char_item(loaded_code()));
         pending_items.push_back(char_item(CODE_NEWLINE));
      end
      queue_random(RANDOM_PER_PHASE);
      queue_text(TAIL_CHARS);
      wait_idle();
      steady = 1'b0;

      // A screen shorter than a glyph, with the undefined pixel mode. The
      // cursor left over from the wide screen may lie past this width, in
      // which case the first glyph is fully clipped.
      set_screen(100, 12, 333, MODE_UNDEFINED);
      queue_random(RANDOM_PER_PHASE);
      queue_text(TAIL_CHARS);
      wait_idle();

      // A width beyond any column the cursor can hold: nothing wraps on the
      // width, and silent codes move the column right without drawing.
      set_screen(8191, 64, $urandom_range(1, 16384), MODE_32BPP);
      queue_text(4);
      repeat (SILENT_RUN) pending_items.push_back(char_item(silent_code()));
      queue_random(RANDOM_PER_PHASE);
      queue_text(TAIL_CHARS);
      wait_idle();

      repeat (2) begin
         random_screen();
         queue_random(RANDOM_PER_PHASE);
         queue_text(TAIL_CHARS);
         wait_idle();
      end

      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

### filelist.f
+incdir+sv
sv/tgr_pkg.sv
sv/tgr_if.sv
sv/tgr_font_mem.sv
sv/tgr_addr_acc.sv
sv/text_console_glyph_renderer.sv
tb/text_console_glyph_renderer_test.sv
